// ===== rtl/core/sdo_pkg.sv =====
// Shared types and constants for the sprite depth ordering unit.
// No dependencies.
package sdo_pkg;
	localparam int CoordW = 20;
	localparam int KeyW   = 44;
	localparam int SheetW = 3;

	localparam logic [1:0] RegEyeX = 2'd0;
	localparam logic [1:0] RegEyeY = 2'd1;
	localparam logic [1:0] RegEyeZ = 2'd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_EMPTY,
		ST_SCAN,
		ST_PICK,
		ST_EMIT
	} sdo_state_t;
endpackage

// ===== rtl/core/sdo_front.sv =====
// Front part: accepts records and computes the ordering key in two stages.
// Depends on sdo_pkg.
module sdo_front import sdo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [5:0]               slot,
	input  logic                     live,
	input  logic                     alpha_blend,
	input  logic [SheetW-1:0]        sheet,
	input  logic signed [CoordW-1:0] pos_x,
	input  logic signed [CoordW-1:0] pos_y,
	input  logic signed [CoordW-1:0] pos_z,
	input  logic                     final_record,
	input  logic signed [CoordW-1:0] eye_x,
	input  logic signed [CoordW-1:0] eye_y,
	input  logic signed [CoordW-1:0] eye_z,
	input  logic [SheetW-1:0]        sheet_max,
	output logic                     q_valid,
	input  logic                     q_stall,
	output logic [KeyW-1:0]          q_key,
	output logic [5:0]               q_slot,
	output logic                     q_alpha,
	output logic                     q_live,
	output logic                     q_final
);
	logic              v_s1, v_s2;
	logic [20:0]       dx_s1, dy_s1, dz_s1;
	logic [5:0]        slot_s1, slot_s2;
	logic              live_s1, alpha_s1, fin_s1, live_s2, alpha_s2, fin_s2;
	logic [SheetW-1:0] sheet_s1;
	logic [KeyW-1:0]   key_s2;
	logic signed [21:0] ddx, ddy, ddz;
	logic [41:0]       sx, sy, sz;
	logic              adv2, adv1;

	assign adv2 = !v_s2 || !q_stall;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	assign ddx = 22'(pos_x) - 22'(eye_x);
	assign ddy = 22'(pos_y) - 22'(eye_y);
	assign ddz = 22'(pos_z) - 22'(eye_z);
	assign sx = 42'(dx_s1) * 42'(dx_s1);
	assign sy = 42'(dy_s1) * 42'(dy_s1);
	assign sz = 42'(dz_s1) * 42'(dz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			dx_s1    <= ddx[21] ? 21'(-ddx) : ddx[20:0];
			dy_s1    <= ddy[21] ? 21'(-ddy) : ddy[20:0];
			dz_s1    <= ddz[21] ? 21'(-ddz) : ddz[20:0];
			slot_s1  <= slot;
			live_s1  <= live;
			alpha_s1 <= alpha_blend;
			fin_s1   <= final_record;
			sheet_s1 <= (sheet > sheet_max) ? sheet_max : sheet;
		end
		if (adv2 && v_s1) begin
			key_s2   <= alpha_s1 ? (KeyW'(sx) + KeyW'(sy) + KeyW'(sz))
			                     : KeyW'(sheet_s1);
			slot_s2  <= slot_s1;
			live_s2  <= live_s1;
			alpha_s2 <= alpha_s1;
			fin_s2   <= fin_s1;
		end
	end

	assign q_valid = v_s2;
	assign q_key   = key_s2;
	assign q_slot  = slot_s2;
	assign q_alpha = alpha_s2;
	assign q_live  = live_s2;
	assign q_final = fin_s2;
endmodule

// ===== rtl/core/sdo_queue.sv =====
// Short queue between the front and back parts.
// Depends on sdo_pkg.
module sdo_queue import sdo_pkg::*; #(
	parameter int W = 53
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_stall,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_take,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] mem_q [4];
	logic [1:0]   wp_q, rp_q;
	logic [2:0]   cnt_q;
	logic         wr, rd;

	assign wr_stall = (cnt_q == 3'd4);
	assign wr = wr_valid && !wr_stall;
	assign rd_valid = (cnt_q != 3'd0);
	assign rd = rd_valid && rd_take;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// ===== rtl/core/sdo_back.sv =====
// Back part: stores live entries, then emits them by repeated selection, or an empty result.
// Depends on sdo_pkg.
module sdo_back import sdo_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_take,
	input  logic [KeyW-1:0] q_key,
	input  logic [5:0]      q_slot,
	input  logic            q_alpha,
	input  logic            q_live,
	input  logic            q_final,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [5:0]      ordered_slot,
	output logic [6:0]      live_total,
	output logic            empty_res,
	output logic            run_end
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Entry memory: key, slot, alpha flag.
	logic [KeyW+6:0] mem_q [SLOTS];
	logic [KeyW+6:0] rdat_q;
	logic [SLOTS-1:0] used_q;
	logic [6:0]  cnt_q, emitted_q;
	logic [IW:0] idx_q;
	logic [IW-1:0] best_idx_q;
	logic [KeyW+6:0] best_q;
	logic        best_ok_q;
	sdo_state_t  st_q, st_d;
	logic        ov_q;
	logic [5:0]  os_q;
	logic        oe_q, oend_q;
	logic [6:0]  ot_q;
	logic        wr, better, cand_ok, out_load;
	logic [IW-1:0] ridx;
	logic [IW-1:0] rd_idx_q;

	assign q_take = (st_q == ST_LOAD) && q_valid;
	assign wr = q_take && q_live && (cnt_q < 7'(SLOTS));
	assign out_load = ((st_q == ST_EMPTY) || (st_q == ST_EMIT)) && (!ov_q || !out_stall);

	// Candidate rdat_q (from rd_idx_q) goes before best_q?
	always_comb begin
		if (rdat_q[0] != best_q[0]) better = rdat_q[0];
		else if (rdat_q[KeyW+6:7] != best_q[KeyW+6:7])
			better = rdat_q[0] ? (rdat_q[KeyW+6:7] > best_q[KeyW+6:7])
			                   : (rdat_q[KeyW+6:7] < best_q[KeyW+6:7]);
		else better = rdat_q[6:1] < best_q[6:1];
	end
	assign cand_ok = !used_q[rd_idx_q];
	assign ridx = idx_q[IW-1:0];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD:  if (q_take && q_final)
				st_d = ((cnt_q == 7'd0) && !wr) ? ST_EMPTY : ST_SCAN;
			ST_EMPTY: if (!ov_q || !out_stall) st_d = ST_LOAD;
			ST_SCAN:  if (idx_q == (IW+1)'(cnt_q)) st_d = ST_PICK;
			ST_PICK:  st_d = ST_EMIT;
			ST_EMIT:  if (!ov_q || !out_stall)
				st_d = (emitted_q + 7'd1 == cnt_q) ? ST_LOAD : ST_SCAN;
			default:  st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			emitted_q <= '0;
			idx_q <= '0;
			used_q <= '0;
			ov_q <= 1'b0;
			best_ok_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (wr) cnt_q <= cnt_q + 7'd1;
					idx_q <= '0;
					best_ok_q <= 1'b0;
					emitted_q <= '0;
					used_q <= '0;
				end
				ST_EMPTY: ;
				ST_SCAN: begin
					// idx_q leads the read data, which is registered in rdat_q (rd_idx_q tracks its index).
					if (idx_q != 0 && cand_ok && (!best_ok_q || better)) begin
						best_ok_q <= 1'b1;
					end
					if (idx_q != (IW+1)'(cnt_q)) idx_q <= idx_q + 1'b1;
				end
				// The last stored entry was judged in the final scan cycle.
				ST_PICK: ;
				ST_EMIT: if (out_load) begin
					used_q[best_idx_q] <= 1'b1;
					emitted_q <= emitted_q + 7'd1;
					idx_q <= '0;
					best_ok_q <= 1'b0;
					if (emitted_q + 7'd1 == cnt_q) cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[cnt_q[IW-1:0]] <= {q_key, q_slot, q_alpha};
		rdat_q <= mem_q[ridx];
		rd_idx_q <= ridx;
		if (st_q == ST_SCAN && idx_q != 0 && cand_ok && (!best_ok_q || better)) begin
			best_q <= rdat_q;
			best_idx_q <= rd_idx_q;
		end
		if (st_q == ST_EMPTY && (!ov_q || !out_stall)) begin
			os_q <= '0; ot_q <= '0; oe_q <= 1'b1; oend_q <= 1'b1;
		end
		if (st_q == ST_EMIT && (!ov_q || !out_stall)) begin
			os_q <= best_q[6:1];
			ot_q <= cnt_q;
			oe_q <= 1'b0;
			oend_q <= (emitted_q + 7'd1 == cnt_q);
		end
	end

	assign out_valid = ov_q;
	assign ordered_slot = os_q;
	assign live_total = ot_q;
	assign empty_res = oe_q;
	assign run_end = oend_q;
endmodule

// ===== rtl/core/sprite_depth_ordering_unit.sv =====
// Sprite depth ordering unit: records load at one per cycle while in_stall is low,
// through a two stage key pipeline and a four entry queue. After the final
// record each result takes one selection pass over the stored entries, read
// through the single read port of the entry store.
// Reset (arst_n, asynchronous) clears control state and eye registers; the
// entry store is not cleared.
module sprite_depth_ordering_unit import sdo_pkg::*; #(
	parameter int SLOTS = 64,
	parameter int SHEET_LIMIT = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [5:0]               slot,
	input  logic                     live,
	input  logic                     alpha_blend,
	input  logic [SheetW-1:0]        sheet,
	input  logic signed [CoordW-1:0] pos_x,
	input  logic signed [CoordW-1:0] pos_y,
	input  logic signed [CoordW-1:0] pos_z,
	input  logic                     final_record,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CoordW-1:0]        cfg_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [5:0]               ordered_slot,
	output logic [6:0]               live_total,
	output logic                     empty_res,
	output logic                     run_end
);
	localparam logic [SheetW-1:0] SheetMax =
		(SHEET_LIMIT >= 8) ? SheetW'(7) : SheetW'(SHEET_LIMIT - 1);
	localparam int QW = KeyW + 9;

	logic signed [CoordW-1:0] eye_x_q, eye_y_q, eye_z_q;
	logic            fv, fs, qv, qt;
	logic [KeyW-1:0] fk;
	logic [5:0]      fsl;
	logic            fa, fl, ff;
	logic [QW-1:0]   qd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= '0; eye_y_q <= '0; eye_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegEyeX: eye_x_q <= cfg_data;
				RegEyeY: eye_y_q <= cfg_data;
				RegEyeZ: eye_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sdo_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .slot, .live, .alpha_blend, .sheet,
		.pos_x, .pos_y, .pos_z, .final_record,
		.eye_x(eye_x_q), .eye_y(eye_y_q), .eye_z(eye_z_q), .sheet_max(SheetMax),
		.q_valid(fv), .q_stall(fs), .q_key(fk), .q_slot(fsl), .q_alpha(fa),
		.q_live(fl), .q_final(ff)
	);

	sdo_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_stall(fs),
		.wr_data({fk, fsl, fa, fl, ff}),
		.rd_valid(qv), .rd_take(qt), .rd_data(qd)
	);

	sdo_back #(.SLOTS(SLOTS)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_take(qt),
		.q_key(qd[QW-1:9]), .q_slot(qd[8:3]), .q_alpha(qd[2]), .q_live(qd[1]),
		.q_final(qd[0]),
		.out_valid, .out_stall, .ordered_slot, .live_total, .empty_res, .run_end
	);
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for sprite_depth_ordering_unit: loads of particle records in, draw order
// out, each result checked against a behavioural ordering model kept in this file.
// Depends on sdo_pkg and the RTL of the unit only.
module testbench;
	import sdo_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;

	typedef struct packed {
		logic [5:0] slot;
		logic [6:0] total;
		logic       empty;
		logic       last;
	} draw_entry_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [5:0] slot;
	logic live;
	logic alpha_blend;
	logic [SheetW-1:0] sheet;
	logic signed [CoordW-1:0] pos_x;
	logic signed [CoordW-1:0] pos_y;
	logic signed [CoordW-1:0] pos_z;
	logic final_record;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [CoordW-1:0] cfg_data;
	logic out_valid;
	logic out_stall;
	logic [5:0] ordered_slot;
	logic [6:0] live_total;
	logic empty_res;
	logic run_end;

	sprite_depth_ordering_unit dut (.*);

	// Ordering model state.
	logic signed [CoordW-1:0] eye_pos [3];
	logic [KeyW-1:0] held_key [SLOTS];
	logic [5:0] held_slot [SLOTS];
	logic held_alpha [SLOTS];
	int held_count;
	draw_entry_t draw_order_q [$];

	bit quiet;
	int records_sent;
	int results_seen;
	int loads_done;
	int errors;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic logic [KeyW-1:0] dist_sq(logic signed [CoordW-1:0] px,
			logic signed [CoordW-1:0] py, logic signed [CoordW-1:0] pz);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'(px) - longint'(eye_pos[RegEyeX]);
		dy = longint'(py) - longint'(eye_pos[RegEyeY]);
		dz = longint'(pz) - longint'(eye_pos[RegEyeZ]);
		return KeyW'(dx * dx + dy * dy + dz * dz);
	endfunction

	function automatic bit drawn_first(int a, int b);
		if (held_alpha[a] != held_alpha[b])
			return held_alpha[a];
		if (held_key[a] != held_key[b])
			return held_alpha[a] ? (held_key[a] > held_key[b]) : (held_key[a] < held_key[b]);
		return held_slot[a] < held_slot[b];
	endfunction

	// Stores a live record and, on the final record, queues the whole draw order.
	function automatic void predict_order(logic [5:0] s, logic lv, logic ab,
			logic [SheetW-1:0] sh, logic signed [CoordW-1:0] px,
			logic signed [CoordW-1:0] py, logic signed [CoordW-1:0] pz, logic fin);
		int order [SLOTS];
		int j;
		draw_entry_t e;
		if (lv && held_count < SLOTS) begin
			held_slot[held_count] = s;
			held_alpha[held_count] = ab;
			held_key[held_count] = ab ? dist_sq(px, py, pz) : KeyW'(sh);
			held_count++;
		end
		if (!fin)
			return;
		if (held_count == 0) begin
			e = '{slot: '0, total: '0, empty: 1'b1, last: 1'b1};
			draw_order_q.push_back(e);
		end
		for (int i = 0; i < held_count; i++) begin
			j = i;
			while (j > 0 && drawn_first(i, order[j - 1])) begin
				order[j] = order[j - 1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < held_count; i++) begin
			e = '{slot: held_slot[order[i]], total: 7'(held_count), empty: 1'b0,
				last: (i == held_count - 1)};
			draw_order_q.push_back(e);
		end
		held_count = 0;
		loads_done++;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		draw_entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (draw_order_q.size() == 0) begin
				$error("unexpected result: ordered_slot %0d", ordered_slot);
				errors++;
			end else begin
				e = draw_order_q.pop_front();
				if (ordered_slot !== e.slot && !e.empty) begin
					$error("ordered_slot: expected %0d, got %0d", e.slot, ordered_slot);
					errors++;
				end
				if (live_total !== e.total) begin
					$error("live_total: expected %0d, got %0d", e.total, live_total);
					errors++;
				end
				if (empty_res !== e.empty) begin
					$error("empty_res: expected %0b, got %0b", e.empty, empty_res);
					errors++;
				end
				if (run_end !== e.last) begin
					$error("run_end: expected %0b, got %0b", e.last, run_end);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 9);

	task automatic send_record(logic [5:0] s, logic lv, logic ab, logic [SheetW-1:0] sh,
			logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
			logic signed [CoordW-1:0] pz, logic fin);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		slot <= s;
		live <= lv;
		alpha_blend <= ab;
		sheet <= sh;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		final_record <= fin;
		do
			@(posedge clk);
		while (in_stall);
		predict_order(s, lv, ab, sh, px, py, pz, fin);
		records_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (draw_order_q.size() != 0)
			@(posedge clk);
		// Lets the last selection pass wind down before the unit is touched again.
		repeat (80) @(posedge clk);
	endtask

	task automatic write_eye(logic [1:0] idx, logic signed [CoordW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		eye_pos[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_eye(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
			logic signed [CoordW-1:0] z);
		write_eye(RegEyeX, x);
		write_eye(RegEyeY, y);
		write_eye(RegEyeZ, z);
	endtask

	// Random load of n records; dup_slots allows repeated slots, tie_pos reuses positions.
	task automatic send_load(int n, int live_pct, bit dup_slots, bit tie_pos);
		int pool [64];
		int k;
		int t;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic signed [CoordW-1:0] pz;
		for (int i = 0; i < 64; i++)
			pool[i] = i;
		for (int i = 63; i > 0; i--) begin
			k = $urandom_range(i);
			t = pool[i];
			pool[i] = pool[k];
			pool[k] = t;
		end
		for (int i = 0; i < n; i++) begin
			if (!(tie_pos && i > 0 && $urandom_range(1))) begin
				px = CoordW'($urandom);
				py = CoordW'($urandom);
				pz = CoordW'($urandom);
			end
			send_record((dup_slots || n > 64) ? 6'($urandom) : 6'(pool[i]),
				$urandom_range(99) < live_pct, 1'($urandom_range(1)), SheetW'($urandom),
				px, py, pz, i == n - 1);
		end
	endtask

	task automatic test_directed();
		set_eye('0, '0, '0);
		// An empty load, then a single dead final record.
		send_record(6'd5, 1'b0, 1'b1, 3'd0, '0, '0, '0, 1'b0);
		send_record(6'd63, 1'b0, 1'b0, 3'd7, '0, '0, '0, 1'b1);
		send_record(6'd0, 1'b0, 1'b0, 3'd0, '0, '0, '0, 1'b1);
		// Alpha and additive mix with distance and sheet ties, repeated slot.
		send_record(6'd9, 1'b1, 1'b0, 3'd7, '0, '0, '0, 1'b0);
		send_record(6'd3, 1'b1, 1'b0, 3'd7, '0, '0, '0, 1'b0);
		send_record(6'd9, 1'b1, 1'b1, 3'd0, 20'sd256, '0, '0, 1'b0);
		send_record(6'd2, 1'b1, 1'b1, 3'd0, '0, -20'sd256, '0, 1'b0);
		send_record(6'd9, 1'b1, 1'b1, 3'd0, '0, '0, 20'sd256, 1'b0);
		send_record(6'd1, 1'b1, 1'b0, 3'd0, '0, '0, '0, 1'b0);
		send_record(6'd0, 1'b1, 1'b1, 3'd0, '0, '0, '0, 1'b1);
		wait_drained();
		// Largest distances: eye at one corner, particles at the other.
		set_eye(-20'sd524288, -20'sd524288, -20'sd524288);
		send_record(6'd63, 1'b1, 1'b1, 3'd5, 20'sd524287, 20'sd524287, 20'sd524287, 1'b0);
		send_record(6'd7, 1'b1, 1'b1, 3'd5, 20'sd524287, 20'sd524287, 20'sd524286, 1'b0);
		send_record(6'd8, 1'b1, 1'b1, 3'd2, -20'sd524288, -20'sd524288, -20'sd524288, 1'b0);
		send_record(6'd4, 1'b0, 1'b1, 3'd2, 20'sd1, 20'sd1, 20'sd1, 1'b1);
		wait_drained();
		set_eye(20'sd524287, 20'sd524287, 20'sd524287);
		send_record(6'd10, 1'b1, 1'b1, 3'd1, -20'sd524288, -20'sd524288, -20'sd524288, 1'b0);
		send_record(6'd11, 1'b1, 1'b1, 3'd1, 20'sd524287, 20'sd524287, 20'sd524287, 1'b1);
		wait_drained();
	endtask

	task automatic test_store_full();
		// More live records than the store holds: the surplus is dropped.
		send_load(70, 100, 1'b1, 1'b0);
		send_load(64, 100, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_loads(int n_records);
		int start;
		int n;
		start = records_sent;
		while (records_sent - start < n_records) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
			case ($urandom_range(9))
				0: send_load(n, 0, 1'b0, 1'b0);
				1, 2: send_load(n, 80, 1'b1, 1'b1);
				default: send_load(n, 85, 1'b0, 1'b0);
			endcase
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		slot = '0;
		live = 1'b0;
		alpha_blend = 1'b0;
		sheet = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		final_record = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegEyeX;
		cfg_data = '0;
		out_stall = 1'b0;
		quiet = 1'b0;
		eye_pos = '{default: '0};
		held_count = 0;
		records_sent = 0;
		results_seen = 0;
		loads_done = 0;
		errors = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_store_full();
		test_random_loads(30);
		set_eye(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
		quiet = 1'b1;
		test_random_loads(30);
		quiet = 1'b0;
		set_eye(20'sd524287, -20'sd524288, 20'sd0);
		test_random_loads(30);
		set_eye(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
		test_random_loads(30);

		repeat (50) @(posedge clk);
		$display("testbench: %0d records in %0d loads, %0d ordered results checked",
			records_sent, loads_done, results_seen);
		if (errors == 0 && draw_order_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/sdo_pkg.sv
rtl/core/sdo_front.sv
rtl/core/sdo_queue.sv
rtl/core/sdo_back.sv
rtl/core/sprite_depth_ordering_unit.sv
verif/testbench.sv
